// ===== rtl/pksd_pkg.sv =====
// Shared types, codes and sizes of the per-key serialising dispatcher.
package pksd_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned WORKERS_DEF     = 4;
  localparam int unsigned ID_BITS_DEF     = 8;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned CONN_W   = 8;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned QCOUNT_W = 5;
  localparam int unsigned RCOUNT_W = 3;

  localparam logic [OP_W-1:0] OP_ENQ_TAIL = 2'd0;
  localparam logic [OP_W-1:0] OP_ENQ_HEAD = 2'd1;
  localparam logic [OP_W-1:0] OP_REQUEST  = 2'd2;
  localparam logic [OP_W-1:0] OP_COMPLETE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NOSLOT   = 3'd6;

  typedef struct packed {
    logic                capture;
    logic                enq;
    logic                release_slot;
    logic                scan_start;
    logic                rd_scan;
    logic                scan_next;
    logic                grant;
    logic                rd_next;
    logic                shift_wr;
    logic                shrink;
    logic                set_status;
    logic [STATUS_W-1:0] status_code;
    logic                load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            q_full;
    logic            q_empty;
    logic            slots_full;
    logic            id_hit;
    logic            entry_busy;
    logic            idx_last;
    logic            shift_done;
  } dp_status_t;

endpackage

// ===== rtl/pksd_ctrl.sv =====
// Sequencing state machine of the dispatcher: decode, queue scan, compaction, result hand-off.
module pksd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  pksd_pkg::dp_status_t  status,
  output pksd_pkg::ctl_cmd_t    cmd
);
  import pksd_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_SCAN_RD  = 3'd2;
  localparam logic [2:0] S_SCAN_EV  = 3'd3;
  localparam logic [2:0] S_SHIFT_RD = 3'd4;
  localparam logic [2:0] S_SHIFT_WR = 3'd5;
  localparam logic [2:0] S_FINISH   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.set_status = 1'b1;
        state_nxt      = S_FINISH;
        case (status.op)
          OP_ENQ_TAIL, OP_ENQ_HEAD: begin
            if (status.q_full) begin
              cmd.status_code = ST_FULL;
            end else begin
              cmd.enq         = 1'b1;
              cmd.status_code = ST_QUEUED;
            end
          end
          OP_REQUEST: begin
            if (status.slots_full) begin
              cmd.status_code = ST_NOSLOT;
            end else if (status.q_empty) begin
              cmd.status_code = ST_NONE;
            end else begin
              cmd.set_status = 1'b0;
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN_RD;
            end
          end
          default: begin
            if (status.id_hit) begin
              cmd.release_slot = 1'b1;
              cmd.status_code  = ST_RELEASED;
            end else begin
              cmd.status_code  = ST_UNKNOWN;
            end
          end
        endcase
      end
      S_SCAN_RD: begin
        cmd.rd_scan = 1'b1;
        state_nxt   = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (!status.entry_busy) begin
          cmd.grant       = 1'b1;
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_GRANTED;
          if (status.idx_last) begin
            cmd.shrink = 1'b1;
            state_nxt  = S_FINISH;
          end else begin
            state_nxt  = S_SHIFT_RD;
          end
        end else if (status.idx_last) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_NONE;
          state_nxt       = S_FINISH;
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt     = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        cmd.rd_next = 1'b1;
        state_nxt   = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        if (status.shift_done) begin
          cmd.shrink = 1'b1;
          state_nxt  = S_FINISH;
        end else begin
          state_nxt  = S_SHIFT_RD;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/pksd_dpath.sv =====
// Datapath of the dispatcher: job queue memory, running-id slots, counters and result register.
module pksd_dpath #(
  parameter int unsigned QUEUE_DEPTH = pksd_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned WORKERS     = pksd_pkg::WORKERS_DEF,
  parameter int unsigned ID_BITS     = pksd_pkg::ID_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pksd_pkg::ctl_cmd_t              cmd,
  output pksd_pkg::dp_status_t            status,
  input  logic [pksd_pkg::OP_W-1:0]       in_op,
  input  logic [pksd_pkg::CONN_W-1:0]     in_conn_id,
  input  logic [pksd_pkg::KIND_W-1:0]     in_job_kind,
  input  logic [pksd_pkg::TAG_W-1:0]      in_job_tag,
  output logic [pksd_pkg::STATUS_W-1:0]   out_status,
  output logic [pksd_pkg::CONN_W-1:0]     out_grant_conn_id,
  output logic [pksd_pkg::KIND_W-1:0]     out_grant_kind,
  output logic [pksd_pkg::TAG_W-1:0]      out_grant_tag,
  output logic [pksd_pkg::QCOUNT_W-1:0]   out_queued_count,
  output logic [pksd_pkg::RCOUNT_W-1:0]   out_running_count,
  output logic                            out_drained
);
  import pksd_pkg::*;

  localparam int unsigned ID_W      = (ID_BITS < CONN_W) ? ID_BITS : CONN_W;
  localparam int unsigned PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned MEM_DEPTH = 2 ** PTR_W;
  localparam int unsigned FILL_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TOT_W     = $clog2(WORKERS + 1);
  localparam int unsigned SLOT_W    = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int unsigned ENTRY_W   = ID_W + KIND_W + TAG_W;

  // captured item
  logic [OP_W-1:0]   op_r;
  logic [ID_W-1:0]   id_r;
  logic [KIND_W-1:0] kind_r;
  logic [TAG_W-1:0]  tag_r;

  // queue bookkeeping
  logic [PTR_W-1:0]  head_r;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] index_r;

  // running slots
  logic [WORKERS-1:0] slot_valid_r;
  logic [ID_W-1:0]    slot_id_r [WORKERS];
  logic [TOT_W-1:0]   total_r;

  // grant and result
  logic [ID_W-1:0]     grant_id_r;
  logic [KIND_W-1:0]   grant_kind_r;
  logic [TAG_W-1:0]    grant_tag_r;
  logic [STATUS_W-1:0] res_status_r;

  logic [STATUS_W-1:0] out_status_r;
  logic [CONN_W-1:0]   out_grant_id_r;
  logic [KIND_W-1:0]   out_grant_kind_r;
  logic [TAG_W-1:0]    out_grant_tag_r;
  logic [QCOUNT_W-1:0] out_qcount_r;
  logic [RCOUNT_W-1:0] out_rcount_r;
  logic                out_drained_r;

  // queue memory
  logic [ENTRY_W-1:0] mem_r [MEM_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               mem_we, mem_re;
  logic [PTR_W-1:0]   mem_wa, mem_ra;
  logic [ENTRY_W-1:0] mem_wd;

  logic [ID_W-1:0]   rd_id;
  logic [KIND_W-1:0] rd_kind;
  logic [TAG_W-1:0]  rd_tag;

  logic [SLOT_W-1:0] free_idx, hit_idx;
  logic              hit_found, busy_found;
  logic [FILL_W:0]   index_ext, fill_ext;
  logic [31:0]       fill_wide, total_wide, gid_wide;

  assign rd_id   = rd_data_r[ENTRY_W-1 -: ID_W];
  assign rd_kind = rd_data_r[TAG_W +: KIND_W];
  assign rd_tag  = rd_data_r[TAG_W-1:0];

  assign index_ext = {1'b0, index_r};
  assign fill_ext  = {1'b0, fill_r};

  // slot searches: lowest free slot, slot holding the completed id, busy check of the read entry
  always_comb begin
    free_idx   = '0;
    hit_idx    = '0;
    hit_found  = 1'b0;
    busy_found = 1'b0;
    for (int w = WORKERS - 1; w >= 0; w--) begin
      if (!slot_valid_r[w]) begin
        free_idx = SLOT_W'(w);
      end
      if (slot_valid_r[w] && (slot_id_r[w] == id_r)) begin
        hit_idx   = SLOT_W'(w);
        hit_found = 1'b1;
      end
      if (slot_valid_r[w] && (slot_id_r[w] == rd_id)) begin
        busy_found = 1'b1;
      end
    end
  end

  always_comb begin
    status.op         = op_r;
    status.q_full     = (fill_r == FILL_W'(QUEUE_DEPTH));
    status.q_empty    = (fill_r == '0);
    status.slots_full = (total_r == TOT_W'(WORKERS));
    status.id_hit     = hit_found;
    status.entry_busy = busy_found;
    status.idx_last   = ((index_ext + 1'b1) == fill_ext);
    status.shift_done = ((index_ext + 2'd2) == fill_ext);
  end

  // memory port selection
  always_comb begin
    mem_we = cmd.enq || cmd.shift_wr;
    mem_re = cmd.rd_scan || cmd.rd_next;
    mem_wd = {id_r, kind_r, tag_r};
    if (cmd.shift_wr) begin
      mem_wd = rd_data_r;
      mem_wa = head_r + PTR_W'(index_r);
    end else if (op_r == OP_ENQ_HEAD) begin
      mem_wa = head_r - 1'b1;
    end else begin
      mem_wa = head_r + PTR_W'(fill_r);
    end
    if (cmd.rd_next) begin
      mem_ra = head_r + PTR_W'(index_r) + 1'b1;
    end else begin
      mem_ra = head_r + PTR_W'(index_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem_r[mem_ra];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      fill_r       <= '0;
      total_r      <= '0;
      slot_valid_r <= '0;
    end else begin
      if (cmd.enq) begin
        fill_r <= fill_r + 1'b1;
        if (op_r == OP_ENQ_HEAD) begin
          head_r <= head_r - 1'b1;
        end
      end
      if (cmd.shrink) begin
        fill_r <= fill_r - 1'b1;
      end
      if (cmd.grant) begin
        slot_valid_r[free_idx] <= 1'b1;
        total_r                <= total_r + 1'b1;
      end
      if (cmd.release_slot) begin
        slot_valid_r[hit_idx] <= 1'b0;
        total_r               <= total_r - 1'b1;
      end
    end
  end

  assign fill_wide  = 32'(fill_r);
  assign total_wide = 32'(total_r);
  assign gid_wide   = 32'(grant_id_r);

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r         <= in_op;
      id_r         <= in_conn_id[ID_W-1:0];
      kind_r       <= in_job_kind;
      tag_r        <= in_job_tag;
      grant_id_r   <= '0;
      grant_kind_r <= '0;
      grant_tag_r  <= '0;
    end
    if (cmd.scan_start) begin
      index_r <= '0;
    end else if (cmd.shift_wr || cmd.scan_next) begin
      index_r <= index_r + 1'b1;
    end
    if (cmd.grant) begin
      grant_id_r           <= rd_id;
      grant_kind_r         <= rd_kind;
      grant_tag_r          <= rd_tag;
      slot_id_r[free_idx]  <= rd_id;
    end
    if (cmd.set_status) begin
      res_status_r <= cmd.status_code;
    end
    if (cmd.load_out) begin
      out_status_r     <= res_status_r;
      out_grant_id_r   <= gid_wide[CONN_W-1:0];
      out_grant_kind_r <= grant_kind_r;
      out_grant_tag_r  <= grant_tag_r;
      out_qcount_r     <= fill_wide[QCOUNT_W-1:0];
      out_rcount_r     <= total_wide[RCOUNT_W-1:0];
      out_drained_r    <= (fill_r == '0) && (total_r == '0);
    end
  end

  assign out_status        = out_status_r;
  assign out_grant_conn_id = out_grant_id_r;
  assign out_grant_kind    = out_grant_kind_r;
  assign out_grant_tag     = out_grant_tag_r;
  assign out_queued_count  = out_qcount_r;
  assign out_running_count = out_rcount_r;
  assign out_drained       = out_drained_r;

endmodule

// ===== rtl/per_key_serializing_dispatcher_top.sv =====
// Top level of the per-key serialising job dispatcher: controller plus datapath.
//
// The block holds an ordered queue of jobs (connection id, job kind, payload tag) and a small
// table of connection ids that are running now. Each item accepted on the input channel gives
// exactly one result item. An enqueue at the tail or at the head answers queued, or queue full
// when QUEUE_DEPTH jobs are waiting. A worker request grants the first waiting job whose id is
// not running, removes it from the queue and marks its id as running; it answers no worker slot
// when WORKERS jobs already run, and none eligible when no waiting job qualifies. A completion
// frees its id and answers released, or unknown id. Every result carries the queue and running
// counts after the step and a drained flag. Only the low ID_BITS bits of a connection id are
// kept (at most eight). An enqueue or a completion steps through capture, decode and hand-off,
// and the next item is accepted only after its hand-off. A request also examines queue entries
// in order and then moves each entry behind the granted one forward; examined and moved entries
// together never exceed the jobs waiting. The queue memory is read one entry at a time with a
// registered read; the queue is a ring in that memory, so an insert at the head costs no move.
// The hand-off stalls for as long as an earlier result still waits unaccepted in the output
// register. No clearing pass follows reset: unused queue entries are never read, and the running
// slots clear at once. A finished result waits in the output register while the next item is
// taken.
module per_key_serializing_dispatcher_top #(
  parameter int unsigned QUEUE_DEPTH = pksd_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned WORKERS     = pksd_pkg::WORKERS_DEF,
  parameter int unsigned ID_BITS     = pksd_pkg::ID_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pksd_pkg::OP_W-1:0]       in_op,
  input  logic [pksd_pkg::CONN_W-1:0]     in_conn_id,
  input  logic [pksd_pkg::KIND_W-1:0]     in_job_kind,
  input  logic [pksd_pkg::TAG_W-1:0]      in_job_tag,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pksd_pkg::STATUS_W-1:0]   out_status,
  output logic [pksd_pkg::CONN_W-1:0]     out_grant_conn_id,
  output logic [pksd_pkg::KIND_W-1:0]     out_grant_kind,
  output logic [pksd_pkg::TAG_W-1:0]      out_grant_tag,
  output logic [pksd_pkg::QCOUNT_W-1:0]   out_queued_count,
  output logic [pksd_pkg::RCOUNT_W-1:0]   out_running_count,
  output logic                            out_drained
);
  import pksd_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t dp_status;

  // sequence each item: decode, scan, compact, hand the result over
  pksd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (dp_status),
    .cmd       (cmd)
  );

  // hold the queue, the running ids, the counts and the result register
  pksd_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .WORKERS     (WORKERS),
    .ID_BITS     (ID_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (dp_status),
    .in_op             (in_op),
    .in_conn_id        (in_conn_id),
    .in_job_kind       (in_job_kind),
    .in_job_tag        (in_job_tag),
    .out_status        (out_status),
    .out_grant_conn_id (out_grant_conn_id),
    .out_grant_kind    (out_grant_kind),
    .out_grant_tag     (out_grant_tag),
    .out_queued_count  (out_queued_count),
    .out_running_count (out_running_count),
    .out_drained       (out_drained)
  );

endmodule

// ===== verif/per_key_serializing_dispatcher_top_test.sv =====
// Self-checking testbench for the per-key serialising job dispatcher.
module per_key_serializing_dispatcher_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pksd_pkg::*;

  localparam int unsigned QDEPTH       = QUEUE_DEPTH_DEF;
  localparam int unsigned NWORKERS     = WORKERS_DEF;
  localparam int unsigned RANDOM_ITEMS = 1100;
  // A request scans the whole queue at worst.
  localparam int unsigned DRAIN_CYCLES = 4 * QDEPTH + 16;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_LEN    = 100;

  typedef struct packed {
    logic [CONN_W-1:0] conn;
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
  } job_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CONN_W-1:0] conn;
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
  } job_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CONN_W-1:0]   conn;
    logic [KIND_W-1:0]   kind;
    logic [TAG_W-1:0]    tag;
    logic [QCOUNT_W-1:0] queued;
    logic [RCOUNT_W-1:0] running;
    logic                drained;
  } dispatch_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_op = '0;
  logic [CONN_W-1:0]   in_conn_id = '0;
  logic [KIND_W-1:0]   in_job_kind = '0;
  logic [TAG_W-1:0]    in_job_tag = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [CONN_W-1:0]   out_grant_conn_id;
  logic [KIND_W-1:0]   out_grant_kind;
  logic [TAG_W-1:0]    out_grant_tag;
  logic [QCOUNT_W-1:0] out_queued_count;
  logic [RCOUNT_W-1:0] out_running_count;
  logic                out_drained;

  // Items still to be offered, and results still owed by the block.
  job_item_t        pending_jobs[$];
  dispatch_result_t owed_results[$];

  // Shadow of the dispatcher: the waiting jobs (index 0 at the front) and the worker slots.
  job_t              waiting_jobs[$];
  logic              slot_busy[NWORKERS];
  logic [CONN_W-1:0] slot_conn[NWORKERS];
  int unsigned       busy_total;

  int unsigned items_total;
  int unsigned accepted_count;
  int unsigned result_count;
  int unsigned cycle_count;
  int unsigned fail_count;

  logic [CONN_W-1:0] id_pool[8];

  per_key_serializing_dispatcher_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_conn_id        (in_conn_id),
    .in_job_kind       (in_job_kind),
    .in_job_tag        (in_job_tag),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_grant_conn_id (out_grant_conn_id),
    .out_grant_kind    (out_grant_kind),
    .out_grant_tag     (out_grant_tag),
    .out_queued_count  (out_queued_count),
    .out_running_count (out_running_count),
    .out_drained       (out_drained)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    for (int w = 0; w < NWORKERS; w++) begin
      slot_busy[w] = 1'b0;
      slot_conn[w] = '0;
    end
    busy_total = 0;
  end

  // Apply one item to the shadow state and return the result it must produce.
  function automatic dispatch_result_t dispatch(input job_item_t it);
    dispatch_result_t r;
    job_t             j;
    int               pick;
    logic             blocked;
    logic             placed;
    r = '0;
    r.status = ST_NONE;
    j.conn = it.conn;
    j.kind = it.kind;
    j.tag = it.tag;
    pick = -1;
    placed = 1'b0;
    case (it.op)
      OP_ENQ_TAIL, OP_ENQ_HEAD: begin
        if (waiting_jobs.size() >= QDEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (it.op == OP_ENQ_TAIL) waiting_jobs.insert(waiting_jobs.size(), j);
          else waiting_jobs.insert(0, j);
          r.status = ST_QUEUED;
        end
      end
      OP_REQUEST: begin
        if (busy_total >= NWORKERS) begin
          r.status = ST_NOSLOT;
        end else begin
          // Take the first job in queue order whose connection is not running.
          for (int i = 0; i < waiting_jobs.size() && pick < 0; i++) begin
            blocked = 1'b0;
            for (int w = 0; w < NWORKERS; w++)
              if (slot_busy[w] && slot_conn[w] == waiting_jobs[i].conn) blocked = 1'b1;
            if (!blocked) pick = i;
          end
          if (pick >= 0) begin
            j = waiting_jobs[pick];
            waiting_jobs.delete(pick);
            for (int w = 0; w < NWORKERS; w++) begin
              if (!placed && !slot_busy[w]) begin
                slot_busy[w] = 1'b1;
                slot_conn[w] = j.conn;
                placed = 1'b1;
              end
            end
            busy_total++;
            r.status = ST_GRANTED;
            r.conn = j.conn;
            r.kind = j.kind;
            r.tag = j.tag;
          end
        end
      end
      default: begin
        r.status = ST_UNKNOWN;
        for (int w = 0; w < NWORKERS; w++) begin
          if (r.status == ST_UNKNOWN && slot_busy[w] && slot_conn[w] == it.conn) begin
            slot_busy[w] = 1'b0;
            slot_conn[w] = '0;
            if (busy_total > 0) busy_total--;
            r.status = ST_RELEASED;
          end
        end
      end
    endcase
    r.queued = QCOUNT_W'(waiting_jobs.size());
    r.running = RCOUNT_W'(busy_total);
    r.drained = (waiting_jobs.size() == 0 && busy_total == 0);
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic add_job(input logic [OP_W-1:0] op, input logic [CONN_W-1:0] conn,
                         input logic [KIND_W-1:0] kind, input logic [TAG_W-1:0] tag);
    job_item_t it;
    it.op = op;
    it.conn = conn;
    it.kind = kind;
    it.tag = tag;
    pending_jobs.insert(pending_jobs.size(), it);
    items_total++;
  endtask

  // Idle phases cycle every PHASE_LEN items: none, sender, receiver, both.
  function automatic int unsigned sender_idle_pct(input int unsigned n);
    case ((n / PHASE_LEN) % 4)
      1: return 72;
      3: return 16;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct(input int unsigned n);
    case ((n / PHASE_LEN) % 4)
      2: return 72;
      3: return 16;
      default: return 0;
    endcase
  endfunction

  // Driver: present the next pending item once the current one has gone in.
  always @(posedge clk) begin
    job_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        nxt.op = in_op;
        nxt.conn = in_conn_id;
        nxt.kind = in_job_kind;
        nxt.tag = in_job_tag;
        owed_results.insert(owed_results.size(), dispatch(nxt));
        accepted_count++;
      end
      // Hold valid and payload until accepted; otherwise choose to idle or advance.
      if (!in_valid || in_ready) begin
        if (pending_jobs.size() > 0 && $urandom_range(99) >= sender_idle_pct(accepted_count)) begin
          nxt = pending_jobs.pop_front();
          in_op <= nxt.op;
          in_conn_id <= nxt.conn;
          in_job_kind <= nxt.kind;
          in_job_tag <= nxt.tag;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every accepted result with the oldest owed one.
  always @(posedge clk) begin
    dispatch_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        result_count++;
        if (owed_results.size() == 0) begin
          $error("result item with nothing owed: status %0d", out_status);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          check_field("status", want.status, out_status);
          check_field("grant_conn_id", want.conn, out_grant_conn_id);
          check_field("grant_kind", want.kind, out_grant_kind);
          check_field("grant_tag", want.tag, out_grant_tag);
          check_field("queued_count", want.queued, out_queued_count);
          check_field("running_count", want.running, out_running_count);
          check_field("drained", want.drained, out_drained);
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_stall_pct(result_count));
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned pick;
    int unsigned len;

    // Directed: empty request, unknown completion, both queue ends, field extremes,
    // a job held back behind its running connection, all workers busy, drain to idle.
    add_job(OP_REQUEST, 8'h00, 2'd0, 16'h0000);
    add_job(OP_COMPLETE, 8'h00, 2'd0, 16'h0000);
    add_job(OP_ENQ_TAIL, 8'hFF, 2'd3, 16'hFFFF);
    add_job(OP_ENQ_HEAD, 8'h00, 2'd0, 16'h0000);
    add_job(OP_ENQ_TAIL, 8'hFF, 2'd1, 16'h1234);
    add_job(OP_ENQ_HEAD, 8'h07, 2'd2, 16'h5A5A);
    add_job(OP_REQUEST, 8'h00, 2'd0, 16'h0000);
    add_job(OP_REQUEST, 8'hFF, 2'd3, 16'hFFFF);
    add_job(OP_REQUEST, 8'h00, 2'd0, 16'h0000);
    add_job(OP_REQUEST, 8'h00, 2'd0, 16'h0000);
    add_job(OP_COMPLETE, 8'hFF, 2'd0, 16'h0000);
    add_job(OP_REQUEST, 8'h00, 2'd0, 16'h0000);
    add_job(OP_ENQ_TAIL, 8'h01, 2'd3, 16'hAAAA);
    add_job(OP_ENQ_TAIL, 8'h02, 2'd1, 16'h5555);
    add_job(OP_REQUEST, 8'h00, 2'd0, 16'h0000);
    add_job(OP_REQUEST, 8'h00, 2'd0, 16'h0000);
    add_job(OP_COMPLETE, 8'h07, 2'd0, 16'h0000);
    add_job(OP_COMPLETE, 8'h00, 2'd0, 16'h0000);
    add_job(OP_COMPLETE, 8'hFF, 2'd0, 16'h0000);
    add_job(OP_COMPLETE, 8'h01, 2'd0, 16'h0000);
    add_job(OP_COMPLETE, 8'h01, 2'd0, 16'h0000);
    add_job(OP_REQUEST, 8'h00, 2'd0, 16'h0000);
    add_job(OP_COMPLETE, 8'h02, 2'd0, 16'h0000);

    // A small pool of connections so that ids collide, block and get released.
    id_pool[0] = 8'h00;
    id_pool[1] = 8'hFF;
    for (int p = 2; p < 8; p++) id_pool[p] = CONN_W'($urandom);

    // Random: bursts of enqueues (long ones fill the queue), requests and
    // completions on pooled ids, with a little noise over the full field ranges.
    while (items_total < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 32) begin
        len = ($urandom_range(99) < 15) ? $urandom_range(20, 14) : $urandom_range(4, 1);
        for (int k = 0; k < len; k++)
          add_job(($urandom_range(3) == 0) ? OP_ENQ_HEAD : OP_ENQ_TAIL,
                  id_pool[$urandom_range(7)], KIND_W'($urandom_range(3)), TAG_W'($urandom));
      end else if (pick < 62) begin
        len = $urandom_range(5, 1);
        for (int k = 0; k < len; k++)
          add_job(OP_REQUEST, CONN_W'($urandom), KIND_W'($urandom_range(3)), TAG_W'($urandom));
      end else if (pick < 92) begin
        len = $urandom_range(4, 1);
        for (int k = 0; k < len; k++)
          add_job(OP_COMPLETE, id_pool[$urandom_range(7)], KIND_W'($urandom_range(3)),
                  TAG_W'($urandom));
      end else begin
        len = $urandom_range(3, 1);
        for (int k = 0; k < len; k++)
          add_job(OP_W'($urandom_range(3)), CONN_W'($urandom_range(255)),
                  KIND_W'($urandom_range(3)), TAG_W'($urandom));
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every item to go in and every owed result to come back,
    // then give the block time to show any stray result.
    while (accepted_count < items_total || owed_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
